// ===== rtl/cdnp_pkg.sv =====
// Shared types, codes and constants for the CSV decimal number parser.
// No dependencies; every other file in rtl/ refers to it by scoped name.
package cdnp_pkg;

    // Parameter defaults
    localparam int MAX_ATTRIBUTES_DEF      = 16;
    localparam int MAX_FRACTION_DIGITS_DEF = 9;
    localparam int INTEGER_BITS_DEF        = 15;
    localparam int FRACTION_BITS_DEF       = 16;

    // Fraction numerator and 10^n divisor width (10^9 < 2^30)
    localparam int DEN_W = 30;
    localparam int CNT_W = 4;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_DIGITS = 3'd1;
    localparam logic [2:0] ERR_SIGN      = 3'd2;
    localparam logic [2:0] ERR_POINT     = 3'd3;
    localparam logic [2:0] ERR_CHAR      = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd5;
    localparam logic [2:0] ERR_FRACTION  = 3'd6;
    localparam logic [2:0] ERR_TOO_MANY  = 3'd7;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic [3:0]         attribute_index;
        logic [2:0]         error_code;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] numerator;
        logic [CNT_W-1:0] digit_count;
    } t_div_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SUM,
        S_OUT
    } t_state;

    function automatic logic [DEN_W-1:0] pow10(input logic [CNT_W-1:0] n);
        logic [DEN_W-1:0] p;
        unique case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/csv_decimal_number_parser.sv =====
// Top level: character parser, sequencer and output register.
// Depends on cdnp_pkg and cdnp_frac_div.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//  out     | from block| o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// A character that gives no result, or gives an error result, brings no stall of its own.
// A comma or end marker that completes a number stalls the input while the
// fraction divider makes one quotient bit per cycle and then rounds, and
// while the saturating sum and the sign step follow.
// Reset is synchronous, active low, and leaves the parser ready for a new string.
// The input is also stalled while a result is held by a stalled output.
module csv_decimal_number_parser #(
    parameter int MAX_ATTRIBUTES      = cdnp_pkg::MAX_ATTRIBUTES_DEF,
    parameter int MAX_FRACTION_DIGITS = cdnp_pkg::MAX_FRACTION_DIGITS_DEF,
    parameter int INTEGER_BITS        = cdnp_pkg::INTEGER_BITS_DEF,
    parameter int FRACTION_BITS       = cdnp_pkg::FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cdnp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cdnp_pkg::t_out_item o_out_item
);
    localparam int AW = $clog2(MAX_ATTRIBUTES + 1);
    localparam int DW = cdnp_pkg::DEN_W;
    localparam int CW = cdnp_pkg::CNT_W;
    localparam int WW = INTEGER_BITS + 4;
    localparam int MW = INTEGER_BITS + FRACTION_BITS + 1;
    localparam int EW = (MW > 32) ? MW : 32;

    cdnp_pkg::t_state r_state;
    cdnp_pkg::t_state n_state;

    logic [INTEGER_BITS-1:0] r_whole;
    logic [DW-1:0]           r_frac_num;
    logic [CW-1:0]           r_frac_cnt;
    logic                    r_sign;
    logic                    r_point;
    logic                    r_digit;
    logic [AW-1:0]           r_attr;
    logic                    r_drop;
    logic                    r_term_end;
    logic [31:0]             r_mag;
    logic                    r_out_valid;
    cdnp_pkg::t_out_item     r_out;

    // FSM outputs
    logic in_accept;
    logic out_free;
    logic out_num;
    logic sum_en;

    // character decode
    logic [7:0]    ch;
    logic          eos;
    logic          is_term;
    logic          is_minus;
    logic          is_point;
    logic          is_digit;
    logic [3:0]    dig;
    logic [WW-1:0] whole_next;
    logic [DW-1:0] frac_next;
    logic          err_hit;
    logic [2:0]    err_code;
    logic          num_start;
    logic [AW+3:0] attr_ext;

    cdnp_pkg::t_div_req      div_req;
    logic                    div_done;
    logic [FRACTION_BITS:0]  div_quo;

    logic [EW-1:0] mag_full;
    logic [EW-1:0] mag_limit;
    logic [EW-1:0] mag_sat;

    always_comb begin
        ch       = i_in_item.character;
        eos      = i_in_item.end_of_string;
        is_term  = eos || (ch == cdnp_pkg::CH_COMMA);
        is_minus = ch == cdnp_pkg::CH_MINUS;
        is_point = ch == cdnp_pkg::CH_POINT;
        is_digit = (ch >= cdnp_pkg::CH_ZERO) && (ch <= cdnp_pkg::CH_NINE);
        dig      = 4'(ch - cdnp_pkg::CH_ZERO);
        whole_next = (WW'(r_whole) << 3) + (WW'(r_whole) << 1) + WW'(dig);
        frac_next  = (r_frac_num << 3) + (r_frac_num << 1) + DW'(dig);
    end

    // error classification, first matching rule wins
    always_comb begin
        err_hit  = 1'b1;
        err_code = cdnp_pkg::ERR_NONE;
        priority if (is_term) begin
            if (!r_digit) begin
                err_code = cdnp_pkg::ERR_NO_DIGITS;
            end else if (r_attr >= AW'(MAX_ATTRIBUTES)) begin
                err_code = cdnp_pkg::ERR_TOO_MANY;
            end else begin
                err_hit = 1'b0;
            end
        end else if (is_minus) begin
            err_hit  = r_sign || r_point || r_digit;
            err_code = cdnp_pkg::ERR_SIGN;
        end else if (is_point) begin
            err_hit  = r_point;
            err_code = cdnp_pkg::ERR_POINT;
        end else if (is_digit) begin
            if (r_point) begin
                err_hit  = r_frac_cnt >= CW'(MAX_FRACTION_DIGITS);
                err_code = cdnp_pkg::ERR_FRACTION;
            end else begin
                err_hit  = whole_next[WW-1:INTEGER_BITS] != '0;
                err_code = cdnp_pkg::ERR_OVERFLOW;
            end
        end else begin
            err_code = cdnp_pkg::ERR_CHAR;
        end
    end

    // FSM next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdnp_pkg::S_IDLE: if (in_accept && num_start) n_state = cdnp_pkg::S_DIV;
            cdnp_pkg::S_DIV:  if (div_done) n_state = cdnp_pkg::S_SUM;
            cdnp_pkg::S_SUM:  n_state = cdnp_pkg::S_OUT;
            cdnp_pkg::S_OUT:  if (out_free) n_state = cdnp_pkg::S_IDLE;
            default:          n_state = cdnp_pkg::S_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        o_in_stall = (r_state != cdnp_pkg::S_IDLE) || !out_free;
        in_accept  = i_in_valid && !o_in_stall;
        num_start  = !r_drop && is_term && !err_hit;
        out_num    = (r_state == cdnp_pkg::S_OUT) && out_free;
        sum_en     = r_state == cdnp_pkg::S_SUM;
    end

    always_comb begin
        div_req.start       = in_accept && num_start;
        div_req.numerator   = r_frac_num;
        div_req.digit_count = r_frac_cnt;
    end

    cdnp_frac_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_frac_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // whole and fraction joined, saturated at the top of the magnitude range
    always_comb begin
        mag_full  = (EW'(r_whole) << FRACTION_BITS) + EW'(div_quo);
        mag_limit = (EW'(1) << (MW - 1)) - EW'(1);
        mag_sat   = mag_full[MW-1] ? mag_limit : mag_full;
        attr_ext  = {4'b0000, r_attr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdnp_pkg::S_IDLE;
            r_whole     <= '0;
            r_frac_num  <= '0;
            r_frac_cnt  <= '0;
            r_sign      <= 1'b0;
            r_point     <= 1'b0;
            r_digit     <= 1'b0;
            r_attr      <= '0;
            r_drop      <= 1'b0;
            r_term_end  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_out_valid && i_out_stall) || out_num ||
                           (in_accept && !r_drop && err_hit);
            if (in_accept) begin
                if (r_drop) begin
                    if (eos) begin
                        r_drop <= 1'b0;
                        r_attr <= '0;
                    end
                end else if (err_hit) begin
                    r_whole    <= '0;
                    r_frac_num <= '0;
                    r_frac_cnt <= '0;
                    r_sign     <= 1'b0;
                    r_point    <= 1'b0;
                    r_digit    <= 1'b0;
                    // an error at the end marker also ends the string
                    r_drop     <= !(is_term && eos);
                    if (is_term && eos) r_attr <= '0;
                end else if (is_term) begin
                    r_term_end <= eos;
                end else if (is_minus) begin
                    r_sign <= 1'b1;
                end else if (is_point) begin
                    r_point <= 1'b1;
                end else begin
                    r_digit <= 1'b1;
                    if (r_point) begin
                        r_frac_num <= frac_next;
                        r_frac_cnt <= r_frac_cnt + CW'(1);
                    end else begin
                        r_whole <= whole_next[INTEGER_BITS-1:0];
                    end
                end
            end
            if (out_num) begin
                r_whole    <= '0;
                r_frac_num <= '0;
                r_frac_cnt <= '0;
                r_sign     <= 1'b0;
                r_point    <= 1'b0;
                r_digit    <= 1'b0;
                r_attr     <= r_term_end ? '0 : r_attr + AW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (sum_en) begin
            r_mag <= mag_sat[31:0];
        end
        if (out_num) begin
            r_out.value           <= r_sign ? 32'sd0 - $signed(r_mag) : $signed(r_mag);
            r_out.attribute_index <= attr_ext[3:0];
            r_out.error_code      <= cdnp_pkg::ERR_NONE;
            r_out.last            <= r_term_end;
        end else if (in_accept && !r_drop && err_hit) begin
            r_out.value           <= 32'sd0;
            r_out.attribute_index <= attr_ext[3:0];
            r_out.error_code      <= err_code;
            r_out.last            <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_attr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_attr <= AW'(MAX_ATTRIBUTES))
        else $error("attribute counter beyond limit");

    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac_cnt <= CW'(MAX_FRACTION_DIGITS))
        else $error("fraction digit count beyond limit");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == cdnp_pkg::S_DIV)
        else $error("divider finished outside the divide state");

    a_drop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> !r_sign && !r_point && !r_digit && r_state == cdnp_pkg::S_IDLE)
        else $error("number state left over while dropping characters");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> r_state == cdnp_pkg::S_DIV && !o_out_valid)
        else $error("division started without entering the divide state");

endmodule

// ===== rtl/cdnp_frac_div.sv =====
// Bit-serial restoring divider: round(numerator * 2^FRACTION_BITS / 10^count).
// Depends on cdnp_pkg for the request struct and the power-of-ten table.
module cdnp_frac_div #(
    parameter int FRACTION_BITS = cdnp_pkg::FRACTION_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  cdnp_pkg::t_div_req      i_req,
    output logic                    o_done,
    output logic [FRACTION_BITS:0]  o_quotient
);
    localparam int SW = $clog2(FRACTION_BITS + 1);
    localparam int DW = cdnp_pkg::DEN_W;

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_step;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [FRACTION_BITS:0] r_quo;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW:0]   half_sum;
    logic          round_up;

    // One compare/subtract per cycle; remainder stays below the divisor
    always_comb begin
        shifted  = {r_rem, 1'b0};
        diff     = shifted - {1'b0, r_den};
        ge       = shifted >= {1'b0, r_den};
        half_sum = {1'b0, r_rem} + {2'b00, r_den[DW-1:1]};
        round_up = half_sum >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= SW'(FRACTION_BITS);
            end else if (r_busy) begin
                if (r_step != '0) begin
                    r_step <= r_step - SW'(1);
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.numerator;
            r_den <= cdnp_pkg::pow10(i_req.digit_count);
            r_quo <= '0;
        end else if (r_busy) begin
            if (r_step != '0) begin
                r_rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
                r_quo <= {r_quo[FRACTION_BITS-1:0], ge};
            end else begin
                // round to nearest, ties up
                r_quo <= r_quo + {{FRACTION_BITS{1'b0}}, round_up};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
